/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* sv/bdq_pkg.sv */
// package for the bounded double-ended queue: widths, codes, state and command types
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int KIND_W        = 3;
    localparam int CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_QUERY      = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_UPDATE  = 2'd1,
        ST_READ    = 2'd2,
        ST_RESPOND = 2'd3
    } state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic read;
    } dp_cmd_t;

endpackage

`default_nettype wire

/* sv/bdq_ctrl.sv */
// sequencer for the queue: steps each beat through update, read and respond
`default_nettype none

module bdq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output bdq_pkg::dp_cmd_t     cmd,
    output logic                 busy,
    output logic                 done
);

    bdq_pkg::state_t state_reg;
    bdq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = bdq_pkg::ST_UPDATE;
                end
            end
            bdq_pkg::ST_UPDATE:  state_next = bdq_pkg::ST_READ;
            bdq_pkg::ST_READ:    state_next = bdq_pkg::ST_RESPOND;
            bdq_pkg::ST_RESPOND: state_next = bdq_pkg::ST_IDLE;
            default:             state_next = bdq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.load   = 1'b0;
        cmd.update = 1'b0;
        cmd.read   = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            bdq_pkg::ST_UPDATE:  cmd.update = 1'b1;
            bdq_pkg::ST_READ:    cmd.read   = 1'b1;
            bdq_pkg::ST_RESPOND: done       = 1'b1;
            default:             busy       = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* sv/bdq_datapath.sv */
// queue datapath: ring store, front index, entry count, capacity register, result logic
`default_nettype none

module bdq_datapath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bdq_pkg::dp_cmd_t               cmd,
    input  wire logic [bdq_pkg::KIND_W-1:0]     kind,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] data_value,
    input  wire logic                           cfg_write,
    input  wire logic [bdq_pkg::CAP_W-1:0]      cfg_data,
    output logic                                accepted,
    output logic signed [bdq_pkg::DATA_W-1:0]   front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]   rear_value,
    output logic                                is_empty,
    output logic                                is_full
);

    localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = CW + 1;
    localparam int CAPW = (CW > bdq_pkg::CAP_W) ? CW : bdq_pkg::CAP_W;
    localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(DEPTH - 1);
    localparam logic [SUMW-1:0] DEPTH_SUM = SUMW'(DEPTH);
    localparam logic [CAPW-1:0] DEPTH_CAP = CAPW'(DEPTH);

    logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];

    bdq_pkg::kind_t                   kind_reg;
    logic [bdq_pkg::DATA_W-1:0]       data_reg;
    logic [IDXW-1:0]                  front_reg;
    logic [IDXW-1:0]                  front_next;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [bdq_pkg::CAP_W-1:0]        capacity_reg;
    logic                             ok_reg;
    logic                             ok_next;
    logic [bdq_pkg::DATA_W-1:0]       rd_front_reg;
    logic [bdq_pkg::DATA_W-1:0]       rd_rear_reg;

    logic [CAPW-1:0]                  cap_wide;
    logic [CAPW-1:0]                  eff_cap;
    logic                             full;
    logic                             empty;
    logic [IDXW-1:0]                  front_dec;
    logic [IDXW-1:0]                  front_inc;
    logic [SUMW-1:0]                  back_sum;
    logic [SUMW-1:0]                  rear_sum;
    logic [IDXW-1:0]                  back_addr;
    logic [IDXW-1:0]                  rear_addr;
    logic                             we;
    logic [IDXW-1:0]                  wr_addr;

    // capacity above the ring depth saturates at the depth
    assign cap_wide = CAPW'(capacity_reg);
    assign eff_cap  = (cap_wide > DEPTH_CAP) ? DEPTH_CAP : cap_wide;
    assign full     = CAPW'(count_reg) >= eff_cap;
    assign empty    = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - IDXW'(1);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + IDXW'(1);

    // front + count stays below twice the depth, and so does front + count - 1 unless the queue is empty
    assign back_sum  = SUMW'(front_reg) + SUMW'(count_reg);
    assign rear_sum  = back_sum - SUMW'(1);
    assign back_addr = (back_sum >= DEPTH_SUM) ? IDXW'(back_sum - DEPTH_SUM)
                                               : IDXW'(back_sum);
    assign rear_addr = (rear_sum >= DEPTH_SUM) ? IDXW'(rear_sum - DEPTH_SUM)
                                               : IDXW'(rear_sum);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        ok_next    = ok_reg;
        we         = 1'b0;
        wr_addr    = back_addr;
        if (cmd.update)
        begin
            ok_next = 1'b0;
            case (kind_reg)
                bdq_pkg::KIND_PUSH_FRONT:
                begin
                    if (!full)
                    begin
                        front_next = front_dec;
                        wr_addr    = front_dec;
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                bdq_pkg::KIND_PUSH_BACK:
                begin
                    if (!full)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                bdq_pkg::KIND_POP_FRONT:
                begin
                    if (!empty)
                    begin
                        front_next = front_inc;
                        count_next = count_reg - CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                bdq_pkg::KIND_POP_BACK:
                begin
                    if (!empty)
                    begin
                        count_next = count_reg - CW'(1);
                        ok_next    = 1'b1;
                    end
                end
                bdq_pkg::KIND_QUERY:
                begin
                    ok_next = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg    <= '0;
            count_reg    <= '0;
            capacity_reg <= bdq_pkg::CAP_RESET;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            if (cfg_write)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
        if (cmd.load)
        begin
            kind_reg <= bdq_pkg::kind_t'(kind);
            data_reg <= data_value;
        end
    end

    // ring store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= data_reg;
        end
        if (cmd.read)
        begin
            rd_front_reg <= mem[front_reg];
            rd_rear_reg  <= mem[rear_addr];
        end
    end

    assign accepted    = ok_reg;
    assign is_empty    = empty;
    assign is_full     = full;
    assign front_value = empty ? '1 : rd_front_reg;
    assign rear_value  = empty ? '1 : rd_rear_reg;

endmodule

`default_nettype wire

/* sv/bounded_double_ended_queue.sv */
// top level of the bounded double-ended queue
//
//   channel   handshake              payload
//   command   start / busy           kind, data_value
//   result    done (one cycle)       accepted, front_value, rear_value, is_empty, is_full
//   config    cfg_write              cfg_data (capacity)
//
// one beat at a time: the sequencer steps update, read and respond after accept, then returns to idle
// result strobe comes in the respond state, after update and read; busy stays high through it
// the ring store's registered read port sets the read step
// async reset clears index, count, sequencer and sets capacity to 16; store is not cleared
// the receiver cannot stall: done lasts one cycle and is never held
`default_nettype none

module bounded_double_ended_queue #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [bdq_pkg::KIND_W-1:0]        kind,
    input  wire logic signed [bdq_pkg::DATA_W-1:0] data_value,
    input  wire logic                              cfg_write,
    input  wire logic [bdq_pkg::CAP_W-1:0]         cfg_data,
    output logic                                   done,
    output logic                                   accepted,
    output logic signed [bdq_pkg::DATA_W-1:0]      front_value,
    output logic signed [bdq_pkg::DATA_W-1:0]      rear_value,
    output logic                                   is_empty,
    output logic                                   is_full
);

    bdq_pkg::dp_cmd_t cmd;

    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .data_value  (data_value),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .accepted    (accepted),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

endmodule

`default_nettype wire

/* sv/bdq_checker.sv */
// port-level checker for the queue and its bind to the top level
`default_nettype none

`include "assert_macros.svh"

module bdq_assertions (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic signed [bdq_pkg::DATA_W-1:0] front_value,
    input wire logic signed [bdq_pkg::DATA_W-1:0] rear_value,
    input wire logic                              is_empty
);

    // an accepted beat keeps the block busy and gives no result the next cycle
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done)

    // a result strobe is only seen while a beat is in flight
    `ASSERT_IMPLY(a_done_busy, clk, rst_n, done, busy)

    // a result strobe is a single cycle and frees the block
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done && !busy)

    // an empty queue reports all ones at both ends
    `ASSERT_IMPLY(a_empty_values, clk, rst_n, done && is_empty,
        front_value == -32'sd1 && rear_value == -32'sd1)

endmodule

bind bounded_double_ended_queue bdq_assertions u_bdq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .front_value (front_value),
    .rear_value  (rear_value),
    .is_empty    (is_empty)
);

`default_nettype wire
